### design/hrf_pkg.sv
// Shared types, codes and segment classification functions for the HTTP request framer.
// No dependencies; every other design file refers to this package by scoped names.

package hrf_pkg;

   // Byte values used by the classifier
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] TAB_CHAR   = 8'h09;

   // Segment tags carried with each result byte
   localparam logic [3:0] TAG_METHOD   = 4'd0;
   localparam logic [3:0] TAG_GAP1     = 4'd1;
   localparam logic [3:0] TAG_URL      = 4'd2;
   localparam logic [3:0] TAG_GAP2     = 4'd3;
   localparam logic [3:0] TAG_VERSION  = 4'd4;
   localparam logic [3:0] TAG_LINE_END = 4'd5;
   localparam logic [3:0] TAG_HEADER   = 4'd6;
   localparam logic [3:0] TAG_TERM     = 4'd7;
   localparam logic [3:0] TAG_BODY     = 4'd8;
   localparam logic [3:0] TAG_ERROR    = 4'd9;

   // Completion status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_LINE_END = 3'd1;
   localparam logic [2:0] ST_NO_METHOD_SP = 3'd2;
   localparam logic [2:0] ST_NO_URL_SP   = 3'd3;
   localparam logic [2:0] ST_GAP_AT_EOL  = 3'd4;
   localparam logic [2:0] ST_NO_TERM     = 3'd5;

   // Result queue sizing
   localparam int RESULT_DEPTH = 4;
   localparam int PTR_W        = $clog2(RESULT_DEPTH);
   localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);
   localparam int ROOM_LIMIT   = RESULT_DEPTH - 2;

   // Parser phase; HDR_LF means the held byte is the LF closing a header line
   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_GAP1    = 4'd1,
      PH_URL     = 4'd2,
      PH_GAP2    = 4'd3,
      PH_VERSION = 4'd4,
      PH_LINE_LF = 4'd5,
      PH_HEADER  = 4'd6,
      PH_TERM_LF = 4'd7,
      PH_BODY    = 4'd8,
      PH_FAILED  = 4'd9,
      PH_HDR_LF  = 4'd10
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       after_lf;
      logic [2:0] err;
   } state_type;

   localparam state_type RESET_STATE = '{phase: PH_METHOD, after_lf: 1'b1, err: ST_OK};

   typedef struct packed {
      logic [7:0] data;
      logic [3:0] tag;
      logic       done;
      logic [2:0] status;
   } result_type;

   // Results produced by one input transaction, packed toward slot 0
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic no_room;
   } queue_status_type;

   function automatic logic is_gap(input logic [7:0] b);
      return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
   endfunction

   function automatic logic is_crlf(input logic [7:0] h, input logic [7:0] n,
                                    input logic has_n);
      return has_n && (h == CR_CHAR) && (n == LF_CHAR);
   endfunction

   // Tag for byte h given its lookahead n
   function automatic logic [3:0] classify_tag(input state_type s, input logic [7:0] h,
                                               input logic [7:0] n, input logic has_n);
      logic       crlf;
      logic [3:0] tag;
      crlf = is_crlf(h, n, has_n);
      unique case (s.phase)
         PH_METHOD:  tag = crlf ? TAG_ERROR : ((h == SPACE_CHAR) ? TAG_GAP1 : TAG_METHOD);
         PH_GAP1:    tag = crlf ? TAG_ERROR : (is_gap(h) ? TAG_GAP1 : TAG_URL);
         PH_URL:     tag = crlf ? TAG_ERROR : ((h == SPACE_CHAR) ? TAG_GAP2 : TAG_URL);
         PH_GAP2:    tag = crlf ? TAG_ERROR : (is_gap(h) ? TAG_GAP2 : TAG_VERSION);
         PH_VERSION: tag = crlf ? TAG_LINE_END : TAG_VERSION;
         PH_LINE_LF: tag = TAG_LINE_END;
         PH_HEADER:  tag = (crlf && s.after_lf) ? TAG_TERM : TAG_HEADER;
         PH_HDR_LF:  tag = TAG_HEADER;
         PH_TERM_LF: tag = TAG_TERM;
         PH_BODY:    tag = TAG_BODY;
         default:    tag = TAG_ERROR;
      endcase
      return tag;
   endfunction

   // Parser state after classifying byte h
   function automatic state_type classify_next(input state_type s, input logic [7:0] h,
                                               input logic [7:0] n, input logic has_n);
      logic      crlf;
      state_type nx;
      crlf = is_crlf(h, n, has_n);
      nx   = s;
      unique case (s.phase)
         PH_METHOD: begin
            if (crlf) begin
               nx.phase = PH_FAILED;
               nx.err   = ST_NO_METHOD_SP;
            end else if (h == SPACE_CHAR) begin
               nx.phase = PH_GAP1;
            end
         end
         PH_GAP1: begin
            if (crlf) begin
               nx.phase = PH_FAILED;
               nx.err   = ST_GAP_AT_EOL;
            end else if (!is_gap(h)) begin
               nx.phase = PH_URL;
            end
         end
         PH_URL: begin
            if (crlf) begin
               nx.phase = PH_FAILED;
               nx.err   = ST_NO_URL_SP;
            end else if (h == SPACE_CHAR) begin
               nx.phase = PH_GAP2;
            end
         end
         PH_GAP2: begin
            if (crlf) begin
               nx.phase = PH_FAILED;
               nx.err   = ST_GAP_AT_EOL;
            end else if (!is_gap(h)) begin
               nx.phase = PH_VERSION;
            end
         end
         PH_VERSION: begin
            if (crlf) nx.phase = PH_LINE_LF;
         end
         PH_LINE_LF: begin
            nx.phase    = PH_HEADER;
            nx.after_lf = 1'b1;
         end
         PH_HEADER: begin
            if (crlf) begin
               nx.phase = s.after_lf ? PH_TERM_LF : PH_HDR_LF;
            end else begin
               nx.after_lf = 1'b0;
            end
         end
         PH_HDR_LF: begin
            nx.phase    = PH_HEADER;
            nx.after_lf = 1'b1;
         end
         PH_TERM_LF: nx.phase = PH_BODY;
         PH_BODY:    nx.phase = PH_BODY;
         default:    nx.phase = PH_FAILED;
      endcase
      return nx;
   endfunction

   function automatic logic [2:0] final_status(input state_type s);
      logic [2:0] st;
      unique case (s.phase)
         PH_METHOD, PH_GAP1, PH_URL, PH_GAP2, PH_VERSION: st = ST_NO_LINE_END;
         PH_TERM_LF, PH_BODY: st = ST_OK;
         PH_FAILED:           st = s.err;
         default:             st = ST_NO_TERM;
      endcase
      return st;
   endfunction

endpackage

### design/hrf_parser.sv
// Byte classifier for the HTTP request framer: holds one byte of lookahead and the phase.
// Depends on hrf_pkg for the state, result and push types and the classify functions.

module hrf_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_data,
   output hrf_pkg::push_type push
);

   hrf_pkg::state_type  state_ff, state_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;

   // state after the held byte, and after the incoming byte on the last transaction
   hrf_pkg::state_type  st1, st2;
   hrf_pkg::result_type first_res, last_res;

   // Next state
   always_comb begin
      st1 = held_valid_ff ? hrf_pkg::classify_next(state_ff, held_byte_ff, data_byte, 1'b1)
                          : state_ff;
      st2 = hrf_pkg::classify_next(st1, data_byte, 8'h00, 1'b0);

      state_in      = state_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      if (accept) begin
         held_byte_in = data_byte;
         if (end_of_data) begin
            // message complete: back to the reset state for the next one
            state_in      = hrf_pkg::RESET_STATE;
            held_valid_in = 1'b0;
         end else begin
            state_in      = st1;
            held_valid_in = 1'b1;
         end
      end
   end

   // Results of this transaction
   always_comb begin
      first_res.data   = held_byte_ff;
      first_res.tag    = hrf_pkg::classify_tag(state_ff, held_byte_ff, data_byte, 1'b1);
      first_res.done   = 1'b0;
      first_res.status = hrf_pkg::ST_OK;

      last_res.data    = data_byte;
      last_res.tag     = hrf_pkg::classify_tag(st1, data_byte, 8'h00, 1'b0);
      last_res.done    = 1'b1;
      last_res.status  = hrf_pkg::final_status(st2);

      push.count = accept ? ({1'b0, held_valid_ff} + {1'b0, end_of_data}) : 2'd0;
      push.res0  = held_valid_ff ? first_res : last_res;
      push.res1  = last_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hrf_pkg::RESET_STATE;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // held byte is payload, qualified by held_valid_ff
   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

### design/hrf_result_fifo.sv
// Small result queue for the HTTP request framer: takes up to two results a cycle, gives one.
// Depends on hrf_pkg for the result, push and status types and the queue depth.

module hrf_result_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  hrf_pkg::push_type         push,
   input  logic                      pop,
   output hrf_pkg::result_type       head,
   output hrf_pkg::queue_status_type status
);

   localparam int PW = hrf_pkg::PTR_W;
   localparam int CW = hrf_pkg::CNT_W;

   hrf_pkg::result_type entries_ff [hrf_pkg::RESULT_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [PW-1:0]       wr_next;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(hrf_pkg::RESULT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Pointer and occupancy update
   always_comb begin
      wr_next = ptr_inc(wr_ptr_ff);
      unique case (push.count)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         default: wr_ptr_in = ptr_inc(wr_next);
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.no_room   = (count_ff > CW'(hrf_pkg::ROOM_LIMIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, written in transaction order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wr_ptr_ff] <= push.res0;
      if (push.count == 2'd2) entries_ff[wr_next]   <= push.res1;
   end

endmodule

### design/http_request_framer.sv
// HTTP request framer: tags each request byte with its segment (method, gaps, URL, version,
// line CRLF, headers, terminator, body). Results trail the input by one byte, since a CR
// needs the following byte to tell whether it starts a CRLF. One byte is accepted per cycle
// while req_stall is low; every transaction yields one result, except the first byte of a
// message (none) and the last byte after a held byte (two, the second carrying message_done
// and parse_status). Throughput is one byte per cycle and is bounded by the single result
// port; the four-entry result queue stalls the input while fewer than two entries are free,
// which only happens when the receiver stalls; results are registered in the result queue.
// Depends on hrf_pkg, hrf_parser and hrf_result_fifo.

module http_request_framer (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_data,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic [3:0] rsp_segment_tag,
   output logic       rsp_message_done,
   output logic [2:0] rsp_parse_status
);

   hrf_pkg::push_type         push;
   hrf_pkg::result_type       head;
   hrf_pkg::queue_status_type qstat;
   logic                      req_accept;
   logic                      rsp_accept;

   // Handshakes
   assign req_stall  = qstat.no_room;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = qstat.not_empty;
   assign rsp_accept = rsp_valid && !rsp_stall;

   hrf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_data_byte),
      .end_of_data (req_end_of_data),
      .push        (push)
   );

   hrf_result_fifo u_result_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_accept),
      .head   (head),
      .status (qstat)
   );

   assign rsp_byte_out     = head.data;
   assign rsp_segment_tag  = head.tag;
   assign rsp_message_done = head.done;
   assign rsp_parse_status = head.status;

endmodule

### design/hrf_checker.sv
// Port-level checks for the HTTP request framer, attached to the top level by bind.
// Depends on hrf_pkg for tag and status codes.

module hrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte_out,
   input logic [3:0] rsp_segment_tag,
   input logic       rsp_message_done,
   input logic [2:0] rsp_parse_status
);

   // Status is only reported on the final result of a message
   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_done |-> rsp_parse_status == hrf_pkg::ST_OK)
      else $error("nonzero status on a result that is not done");

   // A clean finish ends in the terminator or the body
   a_ok_ends_in_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done && rsp_parse_status == hrf_pkg::ST_OK |->
      rsp_segment_tag == hrf_pkg::TAG_TERM || rsp_segment_tag == hrf_pkg::TAG_BODY)
      else $error("ok status on a byte outside terminator or body");

   // An error tag at the end means a request-line failure code
   a_error_tag_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done && rsp_segment_tag == hrf_pkg::TAG_ERROR |->
      rsp_parse_status == hrf_pkg::ST_NO_METHOD_SP ||
      rsp_parse_status == hrf_pkg::ST_NO_URL_SP ||
      rsp_parse_status == hrf_pkg::ST_GAP_AT_EOL)
      else $error("error tag with a status that is not a request-line failure");

   // Tags stay within the defined segments
   a_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_tag <= hrf_pkg::TAG_ERROR)
      else $error("segment tag out of range");

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_out) &&
      $stable(rsp_segment_tag) && $stable(rsp_message_done) && $stable(rsp_parse_status))
      else $error("stalled result changed");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_byte_out     (rsp_byte_out),
   .rsp_segment_tag  (rsp_segment_tag),
   .rsp_message_done (rsp_message_done),
   .rsp_parse_status (rsp_parse_status)
);
